>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file dlny_chk.sv
// no dependencies; each macro expects i_clk and i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/dlny_pkg.sv
// shared types, constants and helpers for the delannoy number block
// no dependencies
package dlny_pkg;

    localparam int MAX_INDEX = 127;
    localparam int c_depth   = MAX_INDEX + 1;
    localparam int c_idx_w   = $clog2(c_depth);
    localparam int c_val_w   = 64;

    localparam logic [c_val_w-1:0] c_all_ones = {c_val_w{1'b1}};
    localparam logic [c_val_w-1:0] c_one      = c_val_w'(1);

    // sequencer states
    localparam logic [1:0] c_st_idle = 2'd0;
    localparam logic [1:0] c_st_run  = 2'd1;
    localparam logic [1:0] c_st_done = 2'd2;

    typedef logic [c_idx_w-1:0] t_idx;

    typedef struct packed {
        logic [6:0] row_index;
        logic [6:0] col_index;
    } t_dlny_in;

    typedef struct packed {
        logic [63:0] count_value;
        logic        overflowed;
    } t_dlny_out;

    // one row entry: overflow mark and saturated value
    typedef struct packed {
        logic               ovf;
        logic [c_val_w-1:0] val;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_mem_wr;

    function automatic t_idx clamp_index(input logic [6:0] v);
        if (int'(v) > MAX_INDEX) begin
            return t_idx'(MAX_INDEX);
        end
        return t_idx'(v);
    endfunction

endpackage

>>> rtl/core/dlny_row_mem.sv
// row buffer: one write port, one registered read port
// depends on dlny_pkg
module dlny_row_mem (
    input  logic             i_clk,
    input  dlny_pkg::t_mem_wr i_wr,
    input  dlny_pkg::t_idx    i_rd_addr,
    output dlny_pkg::t_entry  o_rd_data
);

    dlny_pkg::t_entry r_mem [dlny_pkg::c_depth];
    dlny_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/delannoy_number_dp_top.sv
// delannoy number D(m,n) by row-by-row table fill with one shared adder
// depends on dlny_pkg and dlny_row_mem
//
// input channel: i_in_valid / o_in_stall carry a query {row_index, col_index}.
// output channel: o_out_valid / i_out_stall carry {count_value, overflowed}.
// a transfer happens at a clock edge where valid is high and stall is low.
// one query is worked at a time; o_in_stall is high from the transfer until
// the result has moved into the output register.
// a query with both indices nonzero fills its m by n table in the run state and
// then goes to the done state, while an edge query goes straight to done; the three-input saturating
// adder fills one table cell per cycle and the row memory gives one read and
// one write per cycle; the worst case is a 127 by 127 table.
// the result sits in an output register; a new query is taken while it
// waits, and a finished query waits in the done state until that register
// is free. a value that passes 2^64-1 reads as all ones with overflowed set.
// reset (i_rst_n low, synchronous) returns to idle and drops o_out_valid;
// the row memory is not cleared since each query rewrites what it reads.
module delannoy_number_dp_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  dlny_pkg::t_dlny_in   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output dlny_pkg::t_dlny_out  o_out_data
);

    logic [1:0]             r_state, n_state;
    dlny_pkg::t_idx         r_m, n_m;
    dlny_pkg::t_idx         r_n, n_n;
    dlny_pkg::t_idx         r_i, n_i;
    dlny_pkg::t_idx         r_j, n_j;
    dlny_pkg::t_entry       r_left, n_left;
    dlny_pkg::t_entry       r_diag, n_diag;
    dlny_pkg::t_entry       r_res, n_res;
    dlny_pkg::t_entry       r_wr_last, n_wr_last;
    logic                   r_byp, n_byp;
    logic                   r_out_valid, n_out_valid;
    dlny_pkg::t_dlny_out    r_out_data, n_out_data;

    dlny_pkg::t_mem_wr      s_wr;
    dlny_pkg::t_idx         s_rd_addr;
    dlny_pkg::t_entry       s_rd_data;
    dlny_pkg::t_entry       s_up;
    dlny_pkg::t_entry       s_cell;
    logic [dlny_pkg::c_val_w+1:0] s_sum;
    logic                   s_last_col;
    logic                   s_load_out;
    dlny_pkg::t_idx         s_qm, s_qn;

    dlny_row_mem u_row_mem (
        .i_clk     (i_clk),
        .i_wr      (s_wr),
        .i_rd_addr (s_rd_addr),
        .o_rd_data (s_rd_data)
    );

    // datapath for the cell at (r_i, r_j)
    always_comb begin
        if (r_i == dlny_pkg::t_idx'(1)) begin
            // row 0 is all ones and never stored
            s_up = '{ovf: 1'b0, val: dlny_pkg::c_one};
        end else if (r_byp) begin
            s_up = r_wr_last;
        end else begin
            s_up = s_rd_data;
        end
        s_sum = {2'b00, s_up.val} + {2'b00, r_diag.val} + {2'b00, r_left.val};
        s_cell.ovf = s_up.ovf | r_diag.ovf | r_left.ovf
                   | (|s_sum[dlny_pkg::c_val_w+1:dlny_pkg::c_val_w]);
        s_cell.val = s_cell.ovf ? dlny_pkg::c_all_ones : s_sum[dlny_pkg::c_val_w-1:0];
        s_last_col = (r_j == r_n);
        s_rd_addr  = s_last_col ? dlny_pkg::t_idx'(1) : r_j + dlny_pkg::t_idx'(1);
        s_wr.en    = (r_state == dlny_pkg::c_st_run);
        s_wr.addr  = r_j;
        s_wr.data  = s_cell;
        s_qm       = dlny_pkg::clamp_index(i_in_data.row_index);
        s_qn       = dlny_pkg::clamp_index(i_in_data.col_index);
        s_load_out = (r_state == dlny_pkg::c_st_done) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_left      = r_left;
        n_diag      = r_diag;
        n_res       = r_res;
        n_wr_last   = s_cell;
        n_byp       = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            dlny_pkg::c_st_idle: begin
                if (i_in_valid) begin
                    n_m    = s_qm;
                    n_n    = s_qn;
                    n_i    = dlny_pkg::t_idx'(1);
                    n_j    = dlny_pkg::t_idx'(1);
                    n_left = '{ovf: 1'b0, val: dlny_pkg::c_one};
                    n_diag = '{ovf: 1'b0, val: dlny_pkg::c_one};
                    if (s_qm == '0 || s_qn == '0) begin
                        // edge of the table is always one
                        n_res   = '{ovf: 1'b0, val: dlny_pkg::c_one};
                        n_state = dlny_pkg::c_st_done;
                    end else begin
                        n_state = dlny_pkg::c_st_run;
                    end
                end
            end
            dlny_pkg::c_st_run: begin
                // read of the same address just written needs the new value
                n_byp = (s_rd_addr == r_j);
                if (s_last_col) begin
                    n_j    = dlny_pkg::t_idx'(1);
                    n_i    = r_i + dlny_pkg::t_idx'(1);
                    n_left = '{ovf: 1'b0, val: dlny_pkg::c_one};
                    n_diag = '{ovf: 1'b0, val: dlny_pkg::c_one};
                    if (r_i == r_m) begin
                        n_res   = s_cell;
                        n_state = dlny_pkg::c_st_done;
                    end
                end else begin
                    n_j    = r_j + dlny_pkg::t_idx'(1);
                    n_left = s_cell;
                    n_diag = s_up;
                end
            end
            dlny_pkg::c_st_done: begin
                if (s_load_out) begin
                    n_out_valid            = 1'b1;
                    n_out_data.count_value = r_res.val;
                    n_out_data.overflowed  = r_res.ovf;
                    n_state                = dlny_pkg::c_st_idle;
                end
            end
            default: begin
                n_state = dlny_pkg::c_st_idle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlny_pkg::c_st_idle;
            r_out_valid <= 1'b0;
            r_byp       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_byp       <= n_byp;
        end
        r_m        <= n_m;
        r_n        <= n_n;
        r_i        <= n_i;
        r_j        <= n_j;
        r_left     <= n_left;
        r_diag     <= n_diag;
        r_res      <= n_res;
        r_wr_last  <= n_wr_last;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = (r_state != dlny_pkg::c_st_idle);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/dlny_chk.sv
// port-level checker for the delannoy number block, bound to the top level
// depends on dlny_pkg and assert_macros.svh
`include "assert_macros.svh"

module dlny_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input dlny_pkg::t_dlny_in   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input dlny_pkg::t_dlny_out  o_out_data
);

    logic s_in_xfer;
    logic s_out_held;

    assign s_in_xfer  = i_in_valid && !o_in_stall;
    assign s_out_held = o_out_valid && i_out_stall;

    // a stalled result keeps its value
    `ASSERT_NEXT(a_out_hold, s_out_held, o_out_valid && $stable(o_out_data))
    // an overflowed result always reads as all ones
    `ASSERT_SAME(a_ovf_ones, o_out_valid && o_out_data.overflowed,
        o_out_data.count_value == dlny_pkg::c_all_ones)
    // every path count is at least one
    `ASSERT_SAME(a_nonzero, o_out_valid, o_out_data.count_value != 64'd0)
    // a query keeps the input side busy on the next cycle
    `ASSERT_NEXT(a_busy, s_in_xfer, o_in_stall)

endmodule

bind delannoy_number_dp_top dlny_chk u_dlny_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> tb/sv/delannoy_number_dp_top_test.sv
// self-checking testbench for delannoy_number_dp_top: queries of grid indices, D(m,n) results
// depends on dlny_pkg and the rtl of delannoy_number_dp_top
// a ledger class predicts each saturated path count; plain tasks drive the query channel
module delannoy_number_dp_top_test;

    localparam int c_grid_max   = 127;
    localparam int c_idle_limit = 100000;
    localparam int c_print_max  = 40;

    // path counts expected from accepted queries, oldest first
    class delannoy_ledger;
        dlny_pkg::t_dlny_out pending_counts[$];
        logic [63:0] row_val[c_grid_max+1];
        logic        row_ovf[c_grid_max+1];
        int          mismatches = 0;
        int          n_queries  = 0;
        int          n_counts   = 0;
        int          n_saturated = 0;
        int          widest_cells = 0;

        // one row buffer, swept row by row; carries and marked neighbors saturate
        function dlny_pkg::t_dlny_out count_paths(dlny_pkg::t_dlny_in q);
            dlny_pkg::t_dlny_out res;
            int          m;
            int          n;
            logic [63:0] diag;
            logic        diag_ovf;
            logic [63:0] up;
            logic        up_ovf;
            logic        ovf;
            logic [64:0] sum1;
            logic [64:0] sum2;
            m = (int'(q.row_index) > c_grid_max) ? c_grid_max : int'(q.row_index);
            n = (int'(q.col_index) > c_grid_max) ? c_grid_max : int'(q.col_index);
            for (int j = 0; j <= n; j++) begin
                row_val[j] = 64'd1;
                row_ovf[j] = 1'b0;
            end
            for (int i = 1; i <= m; i++) begin
                diag     = row_val[0];
                diag_ovf = row_ovf[0];
                row_val[0] = 64'd1;
                row_ovf[0] = 1'b0;
                for (int j = 1; j <= n; j++) begin
                    up     = row_val[j];
                    up_ovf = row_ovf[j];
                    ovf    = up_ovf | diag_ovf | row_ovf[j-1];
                    sum1   = {1'b0, up} + {1'b0, diag};
                    sum2   = {1'b0, sum1[63:0]} + {1'b0, row_val[j-1]};
                    ovf    = ovf | sum1[64] | sum2[64];
                    diag     = up;
                    diag_ovf = up_ovf;
                    row_val[j] = ovf ? {64{1'b1}} : sum2[63:0];
                    row_ovf[j] = ovf;
                end
            end
            res.count_value = row_val[n];
            res.overflowed  = row_ovf[n];
            if (m * n > widest_cells) begin
                widest_cells = m * n;
            end
            return res;
        endfunction

        function void note_query(dlny_pkg::t_dlny_in q);
            pending_counts.push_back(count_paths(q));
            n_queries++;
        endfunction

        task report_mismatch(string what);
            if (mismatches < c_print_max) begin
                $display("[%0t] MISMATCH: %s", $realtime, what);
            end
            mismatches++;
        endtask

        task check_count(dlny_pkg::t_dlny_out got);
            dlny_pkg::t_dlny_out want;
            n_counts++;
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("result %0h/%0b with no query outstanding",
                                          got.count_value, got.overflowed));
            end else begin
                want = pending_counts.pop_front();
                if (want.overflowed) begin
                    n_saturated++;
                end
                if (got.count_value !== want.count_value) begin
                    report_mismatch($sformatf("count_value %0h, expected %0h",
                                              got.count_value, want.count_value));
                end
                if (got.overflowed !== want.overflowed) begin
                    report_mismatch($sformatf("overflowed %0b, expected %0b",
                                              got.overflowed, want.overflowed));
                end
            end
        endtask
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    dlny_pkg::t_dlny_in  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    dlny_pkg::t_dlny_out o_out_data;

    delannoy_ledger ledger = new();

    int idle_cycles = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int phase_left  = 0;
    int stall_mode  = 0;

    delannoy_number_dp_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #4 i_clk = ~i_clk;

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                ledger.check_count(o_out_data);
            end
            if (i_in_valid && !o_in_stall) begin
                ledger.note_query(i_in_data);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= c_idle_limit) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // receiver stall pattern; one long hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && ledger.n_counts >= 25) begin
            hold_done   <= 1'b1;
            hold_left   <= 400;
            i_out_stall <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                phase_left <= $urandom_range(20, 200);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // offer one query and hold it until the transfer
    task send_query(input int m, input int n);
        dlny_pkg::t_dlny_in q;
        q.row_index = 7'(m);
        q.col_index = 7'(n);
        i_in_valid <= 1'b1;
        i_in_data  <= q;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    // mostly small grids keep the run short; a few span the full index range
    task pick_grid(output int m, output int n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            m = $urandom_range(0, 12);
            n = $urandom_range(0, 12);
        end else if (r < 95) begin
            m = $urandom_range(0, 40);
            n = $urandom_range(0, 40);
        end else begin
            m = $urandom_range(0, c_grid_max);
            n = $urandom_range(0, c_grid_max);
        end
    endtask

    initial begin
        // edges of the index range, overflow boundary near the diagonal, lopsided grids
        int dir_m[20] = '{0, 0, 127, 1, 1, 127, 2, 3, 5, 20, 25, 26, 27, 28,
                          64, 100, 127, 126, 40, 127};
        int dir_n[20] = '{0, 127, 0, 1, 127, 1, 2, 5, 3, 20, 25, 26, 27, 28,
                          64, 10, 126, 127, 0, 127};
        int m;
        int n;
        int burst_left;
        int total;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        burst_left = $urandom_range(1, 12);
        total = 20 + 80;
        for (int k = 0; k < total; k++) begin
            if (k < 20) begin
                m = dir_m[k];
                n = dir_n[k];
            end else begin
                pick_grid(m, n);
            end
            send_query(m, n);
            burst_left--;
            if (burst_left == 0 && k != total - 1) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end
        end
        i_in_valid <= 1'b0;

        while (ledger.pending_counts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("ran %0d queries and checked %0d results, %0d of them saturated",
                 ledger.n_queries, ledger.n_counts, ledger.n_saturated);
        $display("largest grid swept: %0d cells; receiver hold-off exercised: %0d",
                 ledger.widest_cells, hold_done);
        if (ledger.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/dlny_pkg.sv
rtl/core/dlny_row_mem.sv
rtl/core/delannoy_number_dp_top.sv
rtl/core/dlny_chk.sv
tb/sv/delannoy_number_dp_top_test.sv
